// ===== rtl/edd_pkg.sv =====
// shared types and constants for the error diffusion ditherer
// used by edd_step_div, edd_lane and error_diffusion_dither; no dependencies
package edd_pkg;

   localparam int LANES = 3;
   localparam int PIX_W = 8;

   // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for every 16-bit x
   localparam logic [15:0] RECIP_255   = 16'h8081;
   localparam int          RECIP_SHIFT = 23;

   // diffusion weights, sixteenths
   localparam logic [3:0] W_RIGHT      = 4'd7;
   localparam logic [3:0] W_BELOW_LEFT = 4'd3;
   localparam logic [3:0] W_BELOW      = 4'd5;

   localparam logic [7:0]  STEP_RESET = 8'd255;
   localparam logic [10:0] WIDTH_RESET = 11'd1024;

   // register index, paddr[2]
   localparam logic REG_LEVELS = 1'b0;
   localparam logic REG_WIDTH  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC1,
      ST_CALC2,
      ST_FINISH,
      ST_LAST
   } edd_state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic calc1;
      logic calc2;
      logic finish;
      logic last;
   } edd_ctl_type;

   function automatic logic [7:0] levels_eff(input logic [7:0] lv);
      return (lv == 8'd0) ? 8'd1 : lv;
   endfunction

endpackage

// ===== rtl/error_diffusion_dither.sv =====
// top level of the error diffusion ditherer: sequencer, line buffer, csr port, result register
// depends on edd_pkg, edd_step_div and edd_lane
//
// Takes RGB pixels in raster order and returns each one quantized per channel, with the
// quantization error spread to the right and to the row below. A pixel goes through these
// steps from acceptance to its result: accept with line buffer read, correction and first
// multiply, second multiply, error shares with line buffer write; the last pixel of a row
// adds a step for the second line buffer write. A new pixel is taken only once the last
// one is through, since the carry from each pixel to the next runs through two registered
// multiplies and the line buffer has a single write port. A write to levels starts a
// division for the step size during which no pixel is taken.
module error_diffusion_dither #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import edd_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int BUFW = LANES * PIX_W;

   edd_state_type state_ff, state_in;
   edd_ctl_type   ctl;

   logic [7:0]      levels_ff;
   logic [10:0]     width_ff;
   logic [23:0]     k_ff;
   logic [CW-1:0]   col_ff;
   logic [CW-1:0]   cur_col_ff;
   logic            last_ff;
   logic            first_row_ff;
   logic            use_buf_ff;
   logic [CW:0]     fill_ff;
   logic [BUFW-1:0] rd_data_ff;
   logic [BUFW-1:0] tail_ff;
   logic            rsp_valid_ff;
   logic [7:0]      red_ff, green_ff, blue_ff;

   logic [BUFW-1:0] buf_mem [MAX_WIDTH];

   logic            accept;
   logic            go;
   logic            csr_wr;
   logic            lv_wr;
   logic            div_busy;
   logic [7:0]      step;
   logic [CW-1:0]   c_now;
   logic [CMPW-1:0] w_eff;
   logic            last_now;
   logic            wr_en;
   logic [CW-1:0]   wr_addr;
   logic [BUFW-1:0] wr_data;
   logic [CW:0]     wr_top;

   logic [7:0] pix_lane   [LANES];
   logic [7:0] q_lane     [LANES];
   logic [7:0] left_lane  [LANES];
   logic [7:0] below_lane [LANES];
   logic [BUFW-1:0] left_word;
   logic [BUFW-1:0] below_word;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign lv_wr  = csr_wr && (paddr[2] == REG_LEVELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= 8'd1;
         width_ff  <= WIDTH_RESET;
         k_ff      <= {8'd0, RECIP_255};
      end else begin
         if (lv_wr) begin
            levels_ff <= pwdata[7:0];
         end else if (csr_wr) begin
            width_ff <= pwdata[10:0];
         end
         k_ff <= {16'd0, levels_eff(levels_ff)} * {8'd0, RECIP_255};
      end
   end

   always_comb begin
      if (paddr[2] == REG_LEVELS) begin
         prdata = {24'd0, levels_ff};
      end else begin
         prdata = {21'd0, width_ff};
      end
   end

   edd_step_div u_step_div (
      .clock    (clock),
      .reset    (reset),
      .start    (lv_wr),
      .divisor  (levels_eff(pwdata[7:0])),
      .busy     (div_busy),
      .quotient (step)
   );

   // column bookkeeping
   assign accept = req_valid && req_ready;
   assign go     = !rsp_valid_ff || rsp_ready;
   assign c_now  = req_frame_start ? '0 : col_ff;

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = CMPW'(1);
      end else if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = CMPW'(width_ff);
      end
   end

   assign last_now = ({{(CMPW-CW){1'b0}}, c_now} + CMPW'(1)) >= w_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            first_row_ff <= first_row_ff || req_frame_start;
         end
         if (ctl.finish) begin
            if (last_ff) begin
               col_ff       <= '0;
               first_row_ff <= 1'b0;
            end else begin
               col_ff <= cur_col_ff + CW'(1);
            end
         end
         if (wr_en && (wr_top > fill_ff)) begin
            fill_ff <= wr_top;
         end
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_col_ff <= c_now;
         last_ff    <= last_now;
         use_buf_ff <= !(first_row_ff || req_frame_start)
                       && ({1'b0, c_now} < fill_ff);
      end
      if (ctl.finish) begin
         tail_ff  <= below_word;
         red_ff   <= q_lane[0];
         green_ff <= q_lane[1];
         blue_ff  <= q_lane[2];
      end
   end

   // line buffer
   assign wr_top = {1'b0, wr_addr} + (CW+1)'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= buf_mem[c_now];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_CALC1;
         ST_CALC1:  state_in = ST_CALC2;
         ST_CALC2:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (go) begin
               state_in = last_ff ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctl        = '0;
      ctl.last   = last_ff;
      ctl.clear  = req_frame_start;
      wr_en      = 1'b0;
      wr_addr    = cur_col_ff;
      wr_data    = tail_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !div_busy;
            ctl.load  = req_valid && !div_busy;
         end
         ST_CALC1:  ctl.calc1 = 1'b1;
         ST_CALC2:  ctl.calc2 = 1'b1;
         ST_FINISH: begin
            ctl.finish = go;
            wr_en      = go && (cur_col_ff != '0);
            wr_addr    = cur_col_ff - CW'(1);
            wr_data    = left_word;
         end
         ST_LAST:   wr_en = 1'b1;
         default:   ;
      endcase
   end

   // channel lanes
   assign pix_lane[0] = req_red_in;
   assign pix_lane[1] = req_green_in;
   assign pix_lane[2] = req_blue_in;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      edd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .pixel     (pix_lane[i]),
         .buf_err   (use_buf_ff ? rd_data_ff[i*PIX_W +: PIX_W] : 8'd0),
         .k         (k_ff),
         .step      (step),
         .q_out     (q_lane[i]),
         .left_err  (left_lane[i]),
         .below_err (below_lane[i])
      );
      assign left_word[i*PIX_W +: PIX_W]  = left_lane[i];
      assign below_word[i*PIX_W +: PIX_W] = below_lane[i];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CALC1)
      else $error("accepted transaction did not start processing");

   a_last_second_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && go && last_ff |=> state_ff == ST_LAST)
      else $error("row end skipped the tail write");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready
      |=> state_ff == ST_FINISH && $stable(rsp_red_out))
      else $error("pending result overwritten");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (CW+1)'(MAX_WIDTH))
      else $error("line buffer fill count out of range");

endmodule

// ===== rtl/edd_step_div.sv =====
// restoring divider that forms the quantization step 255 / levels, one bit a cycle
// depends on edd_pkg
module edd_step_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] divisor,
   output logic       busy,
   output logic [7:0] quotient
);
   import edd_pkg::*;

   logic       busy_ff;
   logic [2:0] cnt_ff;
   logic [7:0] rem_ff;
   logic [7:0] div_ff;
   logic [7:0] quo_ff;
   logic [8:0] trial;
   logic [8:0] diff;
   logic       fits;
   logic [7:0] rem_in;

   assign trial  = {rem_ff, 1'b1};
   assign diff   = trial - {1'b0, div_ff};
   assign fits   = trial >= {1'b0, div_ff};
   assign rem_in = fits ? diff[7:0] : trial[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         quo_ff  <= STEP_RESET;
         rem_ff  <= 8'd0;
         div_ff  <= 8'd1;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
         rem_ff  <= 8'd0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[6:0], fits};
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/edd_lane.sv =====
// one color channel: error correction, quantization and error shares
// depends on edd_pkg
module edd_lane (
   input  logic                clock,
   input  logic                reset,
   input  edd_pkg::edd_ctl_type ctl,
   input  logic [7:0]          pixel,
   input  logic [7:0]          buf_err,
   input  logic [23:0]         k,
   input  logic [7:0]          step,
   output logic [7:0]          q_out,
   output logic [7:0]          left_err,
   output logic [7:0]          below_err
);
   import edd_pkg::*;

   logic [6:0]  carry_ff;
   logic [6:0]  pend0_ff;
   logic [3:0]  pend1_ff;
   logic [7:0]  pix_ff;
   logic [7:0]  v_ff;
   logic [31:0] p_ff;
   logic [7:0]  q_ff;

   logic [9:0]  sum;
   logic [7:0]  v_in;
   logic [31:0] p_in;
   logic [15:0] q_wide;
   logic [7:0]  e;
   logic [11:0] e7;
   logic [11:0] e3;
   logic [11:0] e5;
   logic [6:0]  right_sh;
   logic [5:0]  bl_sh;
   logic [6:0]  b_sh;
   logic [6:0]  next_a;

   assign sum  = {2'b00, pix_ff} + {3'b000, carry_ff} + {2'b00, buf_err};
   assign v_in = (sum > 10'd255) ? 8'd255 : sum[7:0];
   assign p_in = {24'd0, v_in} * {8'd0, k};

   assign q_wide = {8'd0, p_ff[RECIP_SHIFT +: 8]} * {8'd0, step};

   assign e        = v_ff - q_ff;
   assign e7       = {4'd0, e} * {8'd0, W_RIGHT};
   assign e3       = {4'd0, e} * {8'd0, W_BELOW_LEFT};
   assign e5       = {4'd0, e} * {8'd0, W_BELOW};
   assign right_sh = e7[10:4];
   assign bl_sh    = e3[9:4];
   assign b_sh     = e5[10:4];
   assign next_a   = {3'b000, pend1_ff} + b_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 7'd0;
         pend0_ff <= 7'd0;
         pend1_ff <= 4'd0;
      end else if (ctl.load && ctl.clear) begin
         carry_ff <= 7'd0;
         pend0_ff <= 7'd0;
         pend1_ff <= 4'd0;
      end else if (ctl.finish) begin
         if (ctl.last) begin
            carry_ff <= 7'd0;
            pend0_ff <= 7'd0;
            pend1_ff <= 4'd0;
         end else begin
            carry_ff <= right_sh;
            pend0_ff <= next_a;
            pend1_ff <= e[7:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pix_ff <= pixel;
      end
      if (ctl.calc1) begin
         v_ff <= v_in;
         p_ff <= p_in;
      end
      if (ctl.calc2) begin
         q_ff <= q_wide[7:0];
      end
   end

   assign q_out     = q_ff;
   assign left_err  = {1'b0, pend0_ff} + {2'b00, bl_sh};
   assign below_err = {1'b0, next_a};

endmodule

// ===== bench/error_diffusion_dither_tb.sv =====
// self-checking testbench for error_diffusion_dither: drives pixel frames and
// register writes, predicts each dithered pixel in place and compares results
// depends on edd_pkg and the error_diffusion_dither rtl
`timescale 1ns / 100ps

module error_diffusion_dither_tb;
   import edd_pkg::*;

   localparam int MAX_W = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PIXELS = 700;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [2:0] ADDR_LEVELS = {REG_LEVELS, 2'b00};
   localparam logic [2:0] ADDR_WIDTH = {REG_WIDTH, 2'b00};

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_type;
   typedef enum {TX_STEADY, TX_BURSTY} tx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red_in = 8'd0;
   logic [7:0]  req_green_in = 8'd0;
   logic [7:0]  req_blue_in = 8'd0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   error_diffusion_dither #(.MAX_WIDTH(MAX_W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // dither state mirrored from the block
   logic [7:0]  cfg_levels = 8'd1;
   logic [10:0] cfg_width = WIDTH_RESET;
   int unsigned row_err [MAX_W][3];
   int unsigned carry_right [3];
   int unsigned below_pend [2][3];
   int unsigned col_pos = 0;
   bit          top_row = 1'b1;

   rgb_type     dithered_q [$];
   rgb_type     want;
   rx_mode_type rx_mode = RX_ALWAYS;
   tx_mode_type tx_mode = TX_STEADY;
   int          stall_left = 0;
   int          burst_left = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          pixels_sent = 0;
   int          frames_sent = 0;
   int          settings_used = 0;
   int          results_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, dithered_q.size());
         $display("error_diffusion_dither regression: fail");
         $finish;
      end
   end

   // receiver stall patterns
   always @(negedge clock) begin
      case (rx_mode)
         RX_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 9) < 7);
         end
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_left <= $urandom_range(1, 15);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (dithered_q.size() == 0) begin
            $error("unexpected result transaction: red %0d green %0d blue %0d",
                   rsp_red_out, rsp_green_out, rsp_blue_out);
            error_count++;
         end else begin
            want = dithered_q.pop_front();
            if (rsp_red_out !== want.red) begin
               $error("red_out: expected %0d, got %0d", want.red, rsp_red_out);
               error_count++;
            end
            if (rsp_green_out !== want.green) begin
               $error("green_out: expected %0d, got %0d", want.green, rsp_green_out);
               error_count++;
            end
            if (rsp_blue_out !== want.blue) begin
               $error("blue_out: expected %0d, got %0d", want.blue, rsp_blue_out);
               error_count++;
            end
         end
      end
   end

   function automatic void clear_carries();
      for (int ch = 0; ch < 3; ch++) begin
         carry_right[ch] = 0;
         below_pend[0][ch] = 0;
         below_pend[1][ch] = 0;
      end
   endfunction

   function automatic void dither_pixel(input pixel_type p, output rgb_type q);
      int unsigned lv, step_size, w, c, v, qv, e;
      int unsigned px [3];
      int unsigned qo [3];
      int unsigned na [3];
      int unsigned nb [3];
      bit last_col;
      lv = (cfg_levels == 8'd0) ? 1 : cfg_levels;
      step_size = 255 / lv;
      if (p.frame_start) begin
         col_pos = 0;
         top_row = 1'b1;
         clear_carries();
      end
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      last_col = (c + 1 >= w);
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      for (int ch = 0; ch < 3; ch++) begin
         v = px[ch] + carry_right[ch];
         if (!top_row) v += row_err[c][ch];
         if (v > 255) v = 255;
         qv = ((lv * v) / 255) * step_size;
         e = v - qv;
         qo[ch] = qv & 8'hFF;
         if (c > 0) row_err[c - 1][ch] = (below_pend[0][ch] + ((3 * e) >> 4)) & 8'hFF;
         na[ch] = below_pend[1][ch] + ((5 * e) >> 4);
         nb[ch] = e >> 4;
         carry_right[ch] = (7 * e) >> 4;
      end
      if (last_col) begin
         for (int ch = 0; ch < 3; ch++) row_err[c][ch] = na[ch] & 8'hFF;
         clear_carries();
         col_pos = 0;
         top_row = 1'b0;
      end else begin
         for (int ch = 0; ch < 3; ch++) begin
            below_pend[0][ch] = na[ch];
            below_pend[1][ch] = nb[ch];
         end
         col_pos = c + 1;
      end
      q.red = 8'(qo[0]);
      q.green = 8'(qo[1]);
      q.blue = 8'(qo[2]);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(input pixel_type p);
      rgb_type q;
      req_valid <= 1'b1;
      req_red_in <= p.red;
      req_green_in <= p.green;
      req_blue_in <= p.blue;
      req_frame_start <= p.frame_start;
      do @(posedge clock); while (!req_ready);
      dither_pixel(p, q);
      dithered_q.insert(dithered_q.size(), q);
      pixels_sent++;
      if (p.frame_start) frames_sent++;
      @(negedge clock);
   endtask

   task automatic pace_sender();
      if (tx_mode == TX_BURSTY) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (dithered_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_LEVELS) cfg_levels = data[7:0];
      else cfg_width = data[10:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] expected);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== expected) begin
         $error("prdata at %0d: expected %0d, got %0d", addr, expected, prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] lv, input logic [31:0] w);
      drain();
      csr_write(ADDR_LEVELS, lv);
      csr_write(ADDR_WIDTH, w);
      csr_check(ADDR_LEVELS, {24'd0, lv[7:0]});
      csr_check(ADDR_WIDTH, {21'd0, w[10:0]});
      settings_used++;
   endtask

   function automatic pixel_type make_pixel(input int style, input bit fs);
      pixel_type p;
      logic [7:0] base;
      case (style)
         0: begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
         end
         1: begin
            p.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.green = $urandom_range(0, 1) ? 8'd254 : 8'd1;
            p.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         default: begin
            base = 8'($urandom);
            p.red = base;
            p.green = base ^ 8'($urandom_range(0, 7));
            p.blue = ~base;
         end
      endcase
      p.frame_start = fs;
      return p;
   endfunction

   task automatic test_reset_values();
      csr_check(ADDR_LEVELS, 32'd1);
      csr_check(ADDR_WIDTH, {21'd0, WIDTH_RESET});
      settings_used++;
      send_pixel('{8'd0, 8'd0, 8'd0, 1'b1});
      send_pixel('{8'd255, 8'd255, 8'd255, 1'b0});
      send_pixel('{8'd128, 8'd64, 8'd254, 1'b0});
      send_pixel('{8'd1, 8'd127, 8'd200, 1'b0});
   endtask

   task automatic test_level_extremes();
      set_config(32'd255, 32'd2);
      send_pixel('{8'd255, 8'd0, 8'd128, 1'b1});
      send_pixel('{8'd0, 8'd255, 8'd77, 1'b0});
      send_pixel('{8'd170, 8'd85, 8'd1, 1'b0});
      send_pixel('{8'd254, 8'd2, 8'd255, 1'b0});
      // zero level factor behaves as one
      set_config(32'd0, 32'd3);
      send_pixel('{8'd200, 8'd127, 8'd128, 1'b1});
      send_pixel('{8'd200, 8'd127, 8'd128, 1'b0});
      send_pixel('{8'd60, 8'd250, 8'd0, 1'b0});
   endtask

   task automatic test_width_extremes();
      // zero and one width give one-pixel rows
      set_config(32'd3, 32'd0);
      send_pixel('{8'd100, 8'd200, 8'd50, 1'b1});
      send_pixel('{8'd100, 8'd200, 8'd50, 1'b0});
      send_pixel('{8'd100, 8'd200, 8'd50, 1'b0});
      set_config(32'd5, 32'd1);
      send_pixel('{8'd33, 8'd190, 8'd222, 1'b1});
      send_pixel('{8'd33, 8'd190, 8'd222, 1'b0});
      // over-wide saturates, upper write bits are dropped
      set_config(32'hFFFF_FF08, 32'hFFFF_FFFF);
      send_pixel('{8'd255, 8'd128, 8'd7, 1'b1});
      send_pixel('{8'd0, 8'd129, 8'd250, 1'b0});
   endtask

   task automatic test_width_shrink_mid_row();
      set_config(32'd4, 32'd8);
      send_pixel('{8'd90, 8'd180, 8'd45, 1'b1});
      send_pixel('{8'd91, 8'd181, 8'd46, 1'b0});
      send_pixel('{8'd92, 8'd182, 8'd47, 1'b0});
      drain();
      csr_write(ADDR_WIDTH, 32'd3);
      settings_used++;
      send_pixel('{8'd93, 8'd183, 8'd48, 1'b0});
      send_pixel('{8'd94, 8'd184, 8'd49, 1'b0});
   endtask

   task automatic test_frame_restart_mid_row();
      set_config(32'd6, 32'd5);
      send_pixel('{8'd240, 8'd15, 8'd100, 1'b1});
      send_pixel('{8'd241, 8'd16, 8'd101, 1'b0});
      send_pixel('{8'd242, 8'd17, 8'd102, 1'b1});
      send_pixel('{8'd243, 8'd18, 8'd103, 1'b0});
   endtask

   task automatic test_random_frames();
      int unsigned lv, w, w_eff, rows, frames, style, sent;
      bit fs, cut;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 7))
            0: lv = 1;
            1: lv = 255;
            2: lv = 0;
            3: lv = 2;
            default: lv = $urandom_range(1, 255);
         endcase
         case ($urandom_range(0, 11))
            0: w = $urandom_range(0, 1);
            1: w = $urandom_range(65, 300);
            default: w = $urandom_range(2, 24);
         endcase
         set_config(lv, w);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         tx_mode = tx_mode_type'($urandom_range(0, 1));
         w_eff = (w < 1) ? 1 : w;
         rows = (w_eff > 64) ? 2 : $urandom_range(1, 6);
         frames = $urandom_range(1, 3);
         style = $urandom_range(0, 2);
         for (int f = 0; f < frames && sent < RANDOM_PIXELS; f++) begin
            cut = 1'b0;
            for (int r = 0; r < rows && !cut; r++) begin
               for (int x = 0; x < w_eff && !cut; x++) begin
                  // occasional stray frame start or truncated frame
                  fs = (r == 0 && x == 0) || ($urandom_range(0, 99) < 2);
                  send_pixel(make_pixel(($urandom_range(0, 9) == 0) ? 0 : style, fs));
                  sent++;
                  if (sent >= RANDOM_PIXELS) cut = 1'b1;
                  if ($urandom_range(0, 199) == 0) cut = 1'b1;
                  if ($urandom_range(0, 99) < 2) begin
                     req_valid <= 1'b0;
                     do @(negedge clock); while (dithered_q.size() != 0);
                  end else begin
                     pace_sender();
                  end
                  if (w_eff > 64 && r == 1 && x > 20) cut = 1'b1;
               end
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_W; i++)
         for (int ch = 0; ch < 3; ch++) row_err[i][ch] = 0;
      clear_carries();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_level_extremes();
      test_width_extremes();
      test_width_shrink_mid_row();
      test_frame_restart_mid_row();
      test_random_frames();

      drain();
      if (dithered_q.size() != 0) begin
         $error("%0d expected pixels never returned", dithered_q.size());
         error_count++;
      end
      $display("%0d pixels in %0d frames dithered under %0d register settings",
               pixels_sent, frames_sent, settings_used);
      $display("%0d results checked, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("error_diffusion_dither regression: pass");
      end else begin
         $display("error_diffusion_dither regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/edd_pkg.sv
rtl/edd_step_div.sv
rtl/edd_lane.sv
rtl/error_diffusion_dither.sv
bench/error_diffusion_dither_tb.sv
